// ===== src/lvd_pkg.sv =====
// Package for the line Voronoi density block: sizes, item structs, divider
// request and response structs, register indexes and sequencer states.
// No dependencies.
package lvd_pkg;

  localparam int MAX_PEDS = 32;
  localparam int PED_AW   = $clog2(MAX_PEDS);
  localparam int CNT_W    = $clog2(MAX_PEDS + 1);

  localparam int ID_W   = 16;
  localparam int POS_W  = 24;
  localparam int VEL_W  = 16;
  localparam int DATA_W = ID_W + POS_W + VEL_W;

  // Working width for neighbours, cell bounds and the doubled interval.
  localparam int CW = 28;

  localparam int DVD_W     = 53;
  localparam int DVS_W     = 26;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam int PADDR_W = 3;

  localparam logic [DVD_W-1:0] DENS_NUM  = DVD_W'(64'd200 << 24);
  localparam logic [14:0]      FD_SCALE  = 15'd25600;
  localparam logic [16:0]      RATIO_ONE = 17'd65536;
  localparam logic [23:0]      MAX24     = 24'hFFFFFF;

  typedef enum logic [0:0] {
    REG_AREA_LEFT  = 1'b0,
    REG_AREA_RIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [ID_W-1:0]         ped_id;
    logic signed [POS_W-1:0] x_position;
    logic signed [VEL_W-1:0] velocity;
    logic                    last;
  } in_t;

  typedef struct packed {
    logic [15:0]        out_id;
    logic [23:0]        person_density;
    logic signed [15:0] person_velocity;
    logic [23:0]        headway;
    logic [23:0]        frame_density;
    logic signed [23:0] frame_velocity;
    logic               is_total;
    logic               too_few;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [19:0] {
    ST_LOAD     = 20'h00001,
    ST_SORT_RD  = 20'h00002,
    ST_SORT_V   = 20'h00004,
    ST_SORT_CMP = 20'h00008,
    ST_SORT_PUT = 20'h00010,
    ST_P_RD     = 20'h00020,
    ST_P_GET    = 20'h00040,
    ST_P_SCAN   = 20'h00080,
    ST_P_NB     = 20'h00100,
    ST_P_CALC   = 20'h00200,
    ST_P_MUL    = 20'h00400,
    ST_P_RAT    = 20'h00800,
    ST_P_WRAT   = 20'h01000,
    ST_P_DEN    = 20'h02000,
    ST_P_WDEN   = 20'h04000,
    ST_P_EMIT   = 20'h08000,
    ST_F_START  = 20'h10000,
    ST_F_WFD    = 20'h20000,
    ST_F_WFV    = 20'h40000,
    ST_F_EMIT   = 20'h80000
  } state_e;

endpackage

// ===== src/lvd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lvd_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lvd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lvd_pkg for widths and the request and response structs.
module lvd_div import lvd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 run_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]     rem_q, dvs_q;
  logic [DVD_W-1:0]     quo_q;
  logic [DVS_W:0]       trial;
  logic                 ge;
  logic [DVS_W:0]       diff;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(DVD_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (run_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign rsp_o.busy     = run_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== src/line_voronoi_density.sv =====
// Line Voronoi density top level: load memory, sorted memory, sequencer and divider.
// Depends on lvd_pkg, lvd_ram and lvd_div.
// Loading takes one item per cycle. After the last item the insertion sort orders the positions;
// each person then scans the sorted memory for its neighbours and uses the shared divider for
// the overlap ratio (skipped for a cell wholly inside or a zero span) and the density (skipped
// for a zero span); an output stall holds the sequencer. The frame total follows the last
// person. Reset clears control state.
module line_voronoi_density import lvd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  state_e state_q, state_d;

  logic signed [POS_W-1:0] area_left_q, area_right_q;
  logic [CNT_W-1:0]        cnt_q, n_q, n_load;
  logic [PED_AW-1:0]       i_q, j_q;
  logic signed [POS_W-1:0] v_q, x_q, prev_q, cur_q;
  logic signed [VEL_W-1:0] vel_q;
  logic [ID_W-1:0]         id_q;
  logic signed [CW-1:0]    l_q, r_q;
  logic [DVS_W-1:0]        ps_q, numer_q;
  logic                    cell_in_q;
  logic signed [42:0]      prod_q;
  logic [21:0]             sum_r_q;
  logic signed [47:0]      sum_v_q;
  logic [16:0]             ratio_q;
  logic [23:0]             dens_q, fd_q;
  logic signed [23:0]      fv_q;
  logic                    few_q;
  out_t                    out_q;
  logic                    out_valid_q;

  // The load memory holds id, position and velocity in load order; the
  // sorted memory holds the positions in ascending order.
  logic                    accept, dram_we, sram_we;
  logic [DATA_W-1:0]       dram_rdata;
  logic [PED_AW-1:0]       sram_raddr;
  logic [POS_W-1:0]        sram_wdata, sram_rdata;
  logic signed [POS_W-1:0] srd;

  assign accept  = (state_q == ST_LOAD) && in_valid_i;
  assign dram_we = accept && (cnt_q < CNT_W'(MAX_PEDS));
  assign n_load  = dram_we ? cnt_q + 1'b1 : cnt_q;

  lvd_ram #(.Width(DATA_W), .Depth(MAX_PEDS)) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (dram_we),
    .waddr_i (cnt_q[PED_AW-1:0]),
    .wdata_i ({in_data_i.ped_id, in_data_i.x_position, in_data_i.velocity}),
    .raddr_i (i_q),
    .rdata_o (dram_rdata)
  );

  lvd_ram #(.Width(POS_W), .Depth(MAX_PEDS)) u_sort_ram (
    .clk_i   (clk_i),
    .we_i    (sram_we),
    .waddr_i (j_q),
    .wdata_i (sram_wdata),
    .raddr_i (sram_raddr),
    .rdata_o (sram_rdata)
  );

  assign srd = sram_rdata;

  // Sort and scan control. An entry read from the sorted memory arrives in the
  // cycle after its address; a shift writes entry j while entry j-2 is read,
  // so a read never meets the write of the same cycle.
  logic shift, i_last, j_more, j_last, hit;

  assign shift  = srd > v_q;
  assign i_last = (CNT_W'(i_q) + 1'b1) == n_q;
  assign j_more = (CNT_W'(j_q) + 1'b1) < n_q;
  assign j_last = (CNT_W'(j_q) + 1'b1) == n_q;
  assign hit    = !j_more || (srd == x_q);

  assign sram_we    = (state_q == ST_SORT_PUT) || ((state_q == ST_SORT_CMP) && shift);
  assign sram_wdata = (state_q == ST_SORT_CMP) ? srd : v_q;

  always_comb begin
    case (state_q)
      ST_SORT_V:   sram_raddr = i_q - 1'b1;
      ST_SORT_CMP: sram_raddr = j_q - 2'd2;
      ST_P_GET:    sram_raddr = '0;
      default:     sram_raddr = j_q + 1'b1;
    endcase
  end

  // Cell of the current person against the doubled measurement interval.
  // Comparisons are strict, so a cell edge on an interval edge matches no case.
  logic signed [CW-1:0] x_ext, al2, ar2, ps, cl, cr, numer_raw, hw_diff;
  logic                 cell_in;
  logic [23:0]          hw;

  assign x_ext   = CW'(x_q);
  assign al2     = CW'(area_left_q) <<< 1;
  assign ar2     = CW'(area_right_q) <<< 1;
  assign ps      = r_q - l_q;
  assign cl      = x_ext + l_q;
  assign cr      = r_q + x_ext;
  assign cell_in = (cl > al2) && (cr < ar2);

  always_comb begin
    numer_raw = '0;
    if (cell_in) begin
      numer_raw = ps;
    end else if (ps != '0) begin
      if ((cr > al2) && (cr < ar2) && (cl < al2)) begin
        numer_raw = cr - al2;
      end else if ((cl < al2) && (cr > ar2)) begin
        numer_raw = ar2 - al2;
      end else if ((cl > al2) && (cl < ar2) && (cr > ar2)) begin
        numer_raw = ar2 - cl;
      end
    end
  end

  // Headway saturates at both ends.
  assign hw_diff = r_q - x_ext;
  assign hw = hw_diff[CW-1] ? 24'd0 :
              (hw_diff > CW'(MAX24)) ? MAX24 : hw_diff[23:0];

  // Shared divider: overlap ratio, individual density and the two frame figures.
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic signed [POS_W:0] w;
  logic [36:0]           fd_num;
  logic [47:0]           abs_sv;
  logic [54:0]           fv_num;

  assign w      = (POS_W+1)'(area_right_q) - (POS_W+1)'(area_left_q);
  assign fd_num = 37'(sum_r_q) * 37'(FD_SCALE);
  assign abs_sv = sum_v_q[47] ? 48'(-sum_v_q) : 48'(sum_v_q);
  assign fv_num = {abs_sv, 7'd0};

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = ps_q;
    case (state_q)
      ST_P_RAT: begin
        div_req.start    = !cell_in_q && (ps_q != '0);
        div_req.dividend = DVD_W'({numer_q, 16'd0});
      end
      ST_P_DEN: begin
        div_req.start    = ps_q != '0;
        div_req.dividend = DENS_NUM;
      end
      ST_F_START: begin
        div_req.start    = w > '0;
        div_req.dividend = DVD_W'(fd_num);
        div_req.divisor  = DVS_W'(w[POS_W-1:0]);
      end
      ST_F_WFD: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = fv_num[DVD_W-1:0];
        div_req.divisor  = DVS_W'(w[POS_W-1:0]);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  lvd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic [DVD_W-1:0] q;
  logic             out_free;

  assign q        = div_rsp.quotient;
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (accept && in_data_i.last) begin
          state_d = (n_load < CNT_W'(2)) ? ST_F_EMIT : ST_SORT_RD;
        end
      end
      ST_SORT_RD:  state_d = ST_SORT_V;
      ST_SORT_V:   state_d = (i_q == '0) ? ST_SORT_PUT : ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (!shift || (j_q == PED_AW'(1))) begin
          state_d = ST_SORT_PUT;
        end
      end
      ST_SORT_PUT: state_d = i_last ? ST_P_RD : ST_SORT_RD;
      ST_P_RD:     state_d = ST_P_GET;
      ST_P_GET:    state_d = ST_P_SCAN;
      ST_P_SCAN: begin
        if (hit) begin
          state_d = ((j_q != '0) && j_last) ? ST_P_CALC : ST_P_NB;
        end
      end
      ST_P_NB:     state_d = ST_P_CALC;
      ST_P_CALC:   state_d = ST_P_MUL;
      ST_P_MUL:    state_d = ST_P_RAT;
      ST_P_RAT: begin
        state_d = (!cell_in_q && (ps_q != '0)) ? ST_P_WRAT : ST_P_DEN;
      end
      ST_P_WRAT:   state_d = div_rsp.done ? ST_P_DEN : ST_P_WRAT;
      ST_P_DEN:    state_d = (ps_q != '0) ? ST_P_WDEN : ST_P_EMIT;
      ST_P_WDEN:   state_d = div_rsp.done ? ST_P_EMIT : ST_P_WDEN;
      ST_P_EMIT: begin
        if (out_free) begin
          state_d = i_last ? ST_F_START : ST_P_RD;
        end
      end
      ST_F_START:  state_d = (w > '0) ? ST_F_WFD : ST_F_EMIT;
      ST_F_WFD:    state_d = div_rsp.done ? ST_F_WFV : ST_F_WFD;
      ST_F_WFV:    state_d = div_rsp.done ? ST_F_EMIT : ST_F_WFV;
      ST_F_EMIT:   state_d = out_free ? ST_LOAD : ST_F_EMIT;
      default:     state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      area_left_q  <= '0;
      area_right_q <= '0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_AREA_RIGHT) begin
          area_right_q <= pwdata[POS_W-1:0];
        end else begin
          area_left_q <= pwdata[POS_W-1:0];
        end
      end
      if (accept) begin
        cnt_q <= in_data_i.last ? '0 : n_load;
      end
      if (((state_q == ST_P_EMIT) || (state_q == ST_F_EMIT)) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        if (accept && in_data_i.last) begin
          n_q     <= n_load;
          i_q     <= '0;
          sum_r_q <= '0;
          sum_v_q <= '0;
          fd_q    <= '0;
          fv_q    <= '0;
          few_q   <= n_load < CNT_W'(2);
        end
      end
      ST_SORT_V: begin
        v_q <= dram_rdata[VEL_W +: POS_W];
        j_q <= i_q;
      end
      ST_SORT_CMP: begin
        if (shift) begin
          j_q <= j_q - 1'b1;
        end
      end
      ST_SORT_PUT: begin
        i_q <= i_last ? '0 : i_q + 1'b1;
      end
      ST_P_GET: begin
        id_q  <= dram_rdata[DATA_W-1 -: ID_W];
        x_q   <= dram_rdata[VEL_W +: POS_W];
        vel_q <= dram_rdata[VEL_W-1:0];
        j_q   <= '0;
      end
      ST_P_SCAN: begin
        if (hit) begin
          cur_q <= srd;
          if ((j_q != '0) && j_last) begin
            l_q <= CW'(prev_q);
            r_q <= (CW'(srd) <<< 1) - CW'(prev_q);
          end
        end else begin
          prev_q <= srd;
          j_q    <= j_q + 1'b1;
        end
      end
      ST_P_NB: begin
        r_q <= CW'(srd);
        l_q <= (j_q == '0) ? (CW'(cur_q) <<< 1) - CW'(srd) : CW'(prev_q);
      end
      ST_P_CALC: begin
        // Width is never negative here; a negative overlap only arises with a
        // reversed interval, whose frame figures are forced to zero.
        ps_q      <= ps[DVS_W-1:0];
        numer_q   <= numer_raw[CW-1] ? '0 : numer_raw[DVS_W-1:0];
        cell_in_q <= cell_in;
      end
      ST_P_MUL: begin
        prod_q <= vel_q * $signed({1'b0, numer_q});
      end
      ST_P_RAT: begin
        sum_v_q <= sum_v_q + 48'(prod_q);
        ratio_q <= cell_in_q ? RATIO_ONE : '0;
      end
      ST_P_WRAT: begin
        if (div_rsp.done) begin
          ratio_q <= q[16:0];
        end
      end
      ST_P_DEN: begin
        sum_r_q <= sum_r_q + 22'(ratio_q);
        dens_q  <= MAX24;
      end
      ST_P_WDEN: begin
        if (div_rsp.done) begin
          dens_q <= (q > DVD_W'(MAX24)) ? MAX24 : q[23:0];
        end
      end
      ST_P_EMIT: begin
        if (out_free) begin
          i_q <= i_q + 1'b1;
        end
      end
      ST_F_WFD: begin
        if (div_rsp.done) begin
          fd_q <= (q > DVD_W'(MAX24)) ? MAX24 : q[23:0];
        end
      end
      ST_F_WFV: begin
        if (div_rsp.done) begin
          if (sum_v_q[47]) begin
            fv_q <= (q > DVD_W'(24'h800000)) ? 24'sh800000 : -$signed(q[23:0]);
          end else begin
            fv_q <= (q > DVD_W'(24'h7FFFFF)) ? 24'sh7FFFFF : $signed(q[23:0]);
          end
        end
      end
      default: begin
      end
    endcase

    if (out_free) begin
      if (state_q == ST_P_EMIT) begin
        out_q <= '{out_id: id_q, person_density: dens_q, person_velocity: vel_q,
                   headway: hw, default: '0};
      end else if (state_q == ST_F_EMIT) begin
        out_q <= '{frame_density: fd_q, frame_velocity: fv_q, is_total: 1'b1,
                   too_few: few_q, last_result: 1'b1, default: '0};
      end
    end
  end

  assign in_stall_o  = state_q != ST_LOAD;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_AREA_RIGHT) ? 32'(area_right_q) : 32'(area_left_q);

  // The divider is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // The fill count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_PEDS))
    else $error("fill count beyond store depth");

  // Once the total is out, loading restarts with an empty store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_F_EMIT) && out_free |=> (cnt_q == '0) && out_valid_q)
    else $error("frame total left state behind");

endmodule
